// ----- design/uei_pkg.sv -----
// Shared constants and types for the undirected edge intern table.
package uei_pkg;

   localparam int EDGE_DEPTH = 256;
   localparam int INDEX_BITS = 16;
   localparam int ADDR_BITS = $clog2(EDGE_DEPTH);
   localparam int COUNT_BITS = $clog2(EDGE_DEPTH + 1);
   localparam int VERTEX_W = 16;
   localparam int SIDE_W = 16;
   localparam int EDGE_INDEX_W = 8;

   typedef struct packed {
      logic                  en;
      logic [ADDR_BITS-1:0]  addr;
      logic [INDEX_BITS-1:0] start_v;
      logic [INDEX_BITS-1:0] end_v;
   } edge_wr_type;

endpackage

// ----- design/uei_edge_store.sv -----
// Endpoint memory of the edge table with one write port and one registered read port.
module uei_edge_store (
   input  logic                           clock,
   input  uei_pkg::edge_wr_type           wr,
   input  logic                           rd_en,
   input  logic [uei_pkg::ADDR_BITS-1:0]  rd_addr,
   output logic [uei_pkg::INDEX_BITS-1:0] rd_start,
   output logic [uei_pkg::INDEX_BITS-1:0] rd_end
);
   import uei_pkg::*;

   logic [2*INDEX_BITS-1:0] mem [EDGE_DEPTH];
   logic [2*INDEX_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= {wr.start_v, wr.end_v};
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_start = rd_data_ff[2*INDEX_BITS-1:INDEX_BITS];
   assign rd_end   = rd_data_ff[INDEX_BITS-1:0];

endmodule

// ----- design/undirected_edge_intern_table_core.sv -----
// Top level of the undirected edge intern table: scan control, side memories and result port.
// An accepted item scans the stored edges in index order until a match or the edge count;
// busy stays high from acceptance until the result, so no new item is taken meanwhile.
// The scan length is set by the linear scan of the endpoint memory, one entry read per cycle.
// The result strobe lasts one cycle and cannot be stalled; busy falls with it.
// Synchronous reset empties the table by clearing the edge count; no memory is swept.
module undirected_edge_intern_table_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [uei_pkg::VERTEX_W-1:0]       req_first_vertex,
   input  logic [uei_pkg::VERTEX_W-1:0]       req_second_vertex,
   input  logic [uei_pkg::SIDE_W-1:0]         req_side_index,
   output logic                               rsp_valid,
   output logic [uei_pkg::EDGE_INDEX_W-1:0]   rsp_edge_index,
   output logic                               rsp_table_full
);
   import uei_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type               state_ff, state_in;
   logic [INDEX_BITS-1:0]   a_ff, a_in;
   logic [INDEX_BITS-1:0]   b_ff, b_in;
   logic [INDEX_BITS-1:0]   s_ff, s_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic [COUNT_BITS-1:0]   issue_ff, issue_in;
   logic                    cmp_valid_ff, cmp_valid_in;
   logic [ADDR_BITS-1:0]    cmp_idx_ff, cmp_idx_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [EDGE_INDEX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic                    rsp_full_ff, rsp_full_in;

   logic                    accept;
   logic                    match;
   logic                    scan_done;
   logic                    rd_en;
   logic [ADDR_BITS-1:0]    rd_addr;
   logic [INDEX_BITS-1:0]   rd_start;
   logic [INDEX_BITS-1:0]   rd_end;
   edge_wr_type             edge_wr;
   logic                    front_we;
   logic                    back_we;
   logic [ADDR_BITS-1:0]    side_addr;
   logic [INDEX_BITS-1:0]   back_data;

   logic [INDEX_BITS-1:0]   front_mem [EDGE_DEPTH];
   logic [INDEX_BITS-1:0]   back_mem [EDGE_DEPTH];

   uei_edge_store u_edge_store (
      .clock    (clock),
      .wr       (edge_wr),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_start (rd_start),
      .rd_end   (rd_end)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign match = cmp_valid_ff &&
                  (((rd_start == a_ff) && (rd_end == b_ff)) ||
                   ((rd_start == b_ff) && (rd_end == a_ff)));
   assign scan_done = (issue_ff == count_ff);

   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      s_in         = s_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      cmp_valid_in = 1'b0;
      cmp_idx_in   = issue_ff[ADDR_BITS-1:0];
      rsp_valid_in = 1'b0;
      rsp_idx_in   = rsp_idx_ff;
      rsp_full_in  = rsp_full_ff;
      rd_en        = 1'b0;
      rd_addr      = issue_ff[ADDR_BITS-1:0];
      edge_wr      = '0;
      front_we     = 1'b0;
      back_we      = 1'b0;
      side_addr    = cmp_idx_ff;
      back_data    = s_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               a_in     = INDEX_BITS'(req_first_vertex);
               b_in     = INDEX_BITS'(req_second_vertex);
               s_in     = INDEX_BITS'(req_side_index);
               issue_in = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (match) begin
               if (rd_start == a_ff) begin
                  front_we = 1'b1;
               end else begin
                  back_we = 1'b1;
               end
               rsp_valid_in = 1'b1;
               rsp_idx_in   = EDGE_INDEX_W'(cmp_idx_ff);
               rsp_full_in  = 1'b0;
               state_in     = ST_IDLE;
            end else if (scan_done) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (count_ff == COUNT_BITS'(EDGE_DEPTH)) begin
                  rsp_idx_in  = '0;
                  rsp_full_in = 1'b1;
               end else begin
                  edge_wr.en      = 1'b1;
                  edge_wr.addr    = count_ff[ADDR_BITS-1:0];
                  edge_wr.start_v = a_ff;
                  edge_wr.end_v   = b_ff;
                  side_addr       = count_ff[ADDR_BITS-1:0];
                  front_we        = 1'b1;
                  back_we         = 1'b1;
                  back_data       = '0;
                  count_in        = count_ff + 1'b1;
                  rsp_idx_in      = EDGE_INDEX_W'(count_ff);
                  rsp_full_in     = 1'b0;
               end
            end else begin
               rd_en        = 1'b1;
               issue_in     = issue_ff + 1'b1;
               cmp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         issue_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         a_ff         <= a_in;
         b_ff         <= b_in;
         s_ff         <= s_in;
         cmp_idx_ff   <= cmp_idx_in;
         rsp_idx_ff   <= rsp_idx_in;
         rsp_full_ff  <= rsp_full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (front_we) begin
         front_mem[side_addr] <= s_ff;
      end
      if (back_we) begin
         back_mem[side_addr] <= back_data;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_edge_index = rsp_idx_ff;
   assign rsp_table_full = rsp_full_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("Accepted item did not raise busy.");

   a_result_ends_scan: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("Busy fell without a result strobe.");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("Result strobe lasted more than one cycle.");

   a_full_index_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_table_full) |-> (rsp_edge_index == '0))
      else $error("Full result carries a nonzero edge index.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(EDGE_DEPTH))
      else $error("Edge count exceeds table depth.");

   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_table_full) |-> (count_ff == COUNT_BITS'(EDGE_DEPTH)))
      else $error("Full reported while table has free entries.");

endmodule
